### src/mcore_pkg.sv
// mcore_pkg: shared types, opcodes and helpers of the integer-subset core.
// Used by mcore_div, mcore_ctrl, mcore_dp and mips32_subset_core_top.
package mcore_pkg;

  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int DIV_STEPS = 32;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_EXEC  = 2'd2;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_SLTI    = 6'h0a;
  localparam logic [5:0] OP_SLTIU   = 6'h0b;
  localparam logic [5:0] OP_ANDI    = 6'h0c;
  localparam logic [5:0] OP_ORI     = 6'h0d;
  localparam logic [5:0] OP_XORI    = 6'h0e;
  localparam logic [5:0] OP_LUI     = 6'h0f;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2b;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_DIV     = 6'h1a;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2a;

  // syscall service numbers in R2
  localparam logic [31:0] SYS_PRINT_INT = 32'd1;
  localparam logic [31:0] SYS_EXIT      = 32'd10;

  localparam logic [4:0] REG_V0 = 5'd2;
  localparam logic [4:0] REG_A0 = 5'd4;
  localparam logic [4:0] REG_RA = 5'd31;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_MWR, S_MRD, S_FETCH, S_DECODE, S_EXEC,
    S_MEMR, S_MEMW, S_DIVW, S_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mem_wr_in;
    logic mem_rd_in;
    logic fetch;
    logic decode;
    logic exec;
    logic mem_rd_addr;
    logic mem_fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       stopped;
    logic       is_load;
    logic       is_store;
    logic       is_div;
    logic       div_done;
    logic       out_busy;
  } status_t;

  // word index of the item, wrapped to the memory depth
  function automatic logic [MEM_AW-1:0] word_idx(input logic [11:0] w);
    logic [31:0] t;
    t = {20'b0, w};
    return t[MEM_AW-1:0];
  endfunction

  // word index of a byte address, wrapped to the memory depth
  function automatic logic [MEM_AW-1:0] byte_idx(input logic [31:0] a);
    logic [31:0] t;
    t = {2'b00, a[31:2]};
    return t[MEM_AW-1:0];
  endfunction

endpackage

### src/mcore_div.sv
// mcore_div: signed 32-bit divider, one quotient bit per cycle.
// Depends on mcore_pkg.
module mcore_div
  import mcore_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic              busy;
  logic              fin;
  logic              by_zero;
  logic              neg_q;
  logic              neg_r;
  logic [DIV_CW-1:0] cnt;
  logic [31:0]       q;
  logic [31:0]       r;
  logic [31:0]       mb;
  logic [31:0]       dvd;
  logic [32:0]       rs;
  logic [32:0]       diff;

  assign rs   = {r, q[31]};
  assign diff = rs - {1'b0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= (divisor != 32'd0);
        fin  <= (divisor == 32'd0);
      end else if (busy && cnt == DIV_CW'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      by_zero <= (divisor == 32'd0);
      neg_q   <= dividend[31] ^ divisor[31];
      neg_r   <= dividend[31];
      dvd     <= dividend;
      q       <= dividend[31] ? 32'd0 - dividend : dividend;
      mb      <= divisor[31] ? 32'd0 - divisor : divisor;
      r       <= 32'd0;
      cnt     <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (!diff[32]) begin
        r <= diff[31:0];
        q <= {q[30:0], 1'b1};
      end else begin
        r <= rs[31:0];
        q <= {q[30:0], 1'b0};
      end
    end
  end

  assign done = fin;
  assign quo  = by_zero ? 32'hffff_ffff : (neg_q ? 32'd0 - q : q);
  assign rem  = by_zero ? dvd : (neg_r ? 32'd0 - r : r);

endmodule

### src/mcore_ctrl.sv
// mcore_ctrl: sequencer of the core; steps each item through its states.
// Depends on mcore_pkg; drives the datapath by cmd_t, reads status_t.
module mcore_ctrl
  import mcore_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_DISP;
      S_DISP: begin
        case (st.mode)
          MODE_WRITE: state_next = S_MWR;
          MODE_READ:  state_next = S_MRD;
          MODE_EXEC:  state_next = st.stopped ? S_DONE : S_FETCH;
          default:    state_next = S_DONE;
        endcase
      end
      S_MWR:    state_next = S_DONE;
      S_MRD:    state_next = S_DONE;
      S_FETCH:  state_next = S_DECODE;
      S_DECODE: state_next = S_EXEC;
      S_EXEC: begin
        if (st.is_div)                     state_next = S_DIVW;
        else if (st.is_load || st.is_store) state_next = S_MEMR;
        else                               state_next = S_DONE;
      end
      S_MEMR:   state_next = S_MEMW;
      S_MEMW:   state_next = S_DONE;
      S_DIVW:   if (st.div_done) state_next = S_DONE;
      S_DONE:   if (!st.out_busy) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    in_stall        = (state != S_IDLE);
    cmd.load_in     = (state == S_IDLE) && in_valid;
    cmd.mem_wr_in   = (state == S_MWR);
    cmd.mem_rd_in   = (state == S_MRD);
    cmd.fetch       = (state == S_FETCH);
    cmd.decode      = (state == S_DECODE);
    cmd.exec        = (state == S_EXEC);
    cmd.mem_rd_addr = (state == S_MEMR);
    cmd.mem_fin     = (state == S_MEMW);
    cmd.out_load    = (state == S_DONE) && !st.out_busy;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> state == S_IDLE) else $error("no return to idle after result");
  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVW && !st.div_done) |=> state == S_DIVW) else $error("left divide wait early");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.fetch, cmd.decode, cmd.exec, cmd.mem_fin, cmd.out_load}))
    else $error("overlapping commands");
  a_exec_order: assert property (@(posedge clk) disable iff (rst)
    state == S_DECODE |=> state == S_EXEC) else $error("decode not followed by execute");

endmodule

### src/mcore_dp.sv
// mcore_dp: datapath with word memory, register file, HI/LO, PC and result register.
// Depends on mcore_pkg and mcore_div; sequenced by mcore_ctrl.
module mcore_dp
  import mcore_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     st,
  input  logic [1:0]  mode,
  input  logic [11:0] word_index,
  input  logic [31:0] write_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_word,
  output logic [31:0] program_counter,
  output logic        halted,
  output logic        print_valid,
  output logic signed [31:0] print_value
);

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] mem_q;
  logic [31:0] rf [32];
  logic [31:0] rf_v;

  logic [1:0]        mode_q;
  logic [MEM_AW-1:0] in_idx;
  logic [31:0]       in_data;
  logic [31:0]       pc, hi, lo, ir, ra_q, rb_q, addr_q;
  logic              stopped, pr_v;
  logic [31:0]       pr_val;

  // decode fields
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [15:0] imm;
  logic [31:0] simm, uimm, pc4, addr;

  logic        x_wen, x_load, x_store, x_div, x_mult, x_stop, x_print;
  logic [4:0]  x_wa;
  logic [31:0] x_wd, x_npc;

  logic [4:0]  rd_a, rd_b;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;

  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [31:0]       mem_wd;
  logic [31:0]       ld_val, st_word, lane_mask, bsh, hsh;
  logic [4:0]        bit_ofs;
  logic [63:0]       prod;

  logic        div_done;
  logic [31:0] div_q, div_r;

  // input latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode_q  <= mode;
      in_idx  <= word_idx(word_index);
      in_data <= write_word;
    end
  end

  // instruction fields, from the fetched word in decode and from ir later
  always_comb begin
    logic [31:0] w;
    w    = cmd.decode ? mem_q : ir;
    op   = w[31:26];
    rs   = w[25:21];
    rt   = w[20:16];
    rd   = w[15:11];
    sh   = w[10:6];
    fn   = w[5:0];
    imm  = w[15:0];
  end

  assign simm = {{16{imm[15]}}, imm};
  assign uimm = {16'b0, imm};
  assign pc4  = pc + 32'd4;
  assign addr = ra_q + simm;

  // syscall reads its service number and argument instead of rs and rt
  always_comb begin
    if (op == OP_SPECIAL && fn == FN_SYSCALL) begin
      rd_a = REG_V0;
      rd_b = REG_A0;
    end else begin
      rd_a = rs;
      rd_b = rt;
    end
  end

  // execute decode
  always_comb begin
    x_wen   = 1'b0;
    x_wa    = rd;
    x_wd    = 32'd0;
    x_npc   = pc4;
    x_load  = 1'b0;
    x_store = 1'b0;
    x_div   = 1'b0;
    x_mult  = 1'b0;
    x_stop  = 1'b0;
    x_print = 1'b0;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_ADD:  begin x_wen = 1'b1; x_wd = ra_q + rb_q; end
          FN_SUB:  begin x_wen = 1'b1; x_wd = ra_q - rb_q; end
          FN_AND:  begin x_wen = 1'b1; x_wd = ra_q & rb_q; end
          FN_OR:   begin x_wen = 1'b1; x_wd = ra_q | rb_q; end
          FN_XOR:  begin x_wen = 1'b1; x_wd = ra_q ^ rb_q; end
          FN_NOR:  begin x_wen = 1'b1; x_wd = ~(ra_q | rb_q); end
          FN_SLT:  begin
            x_wen = 1'b1;
            x_wd  = {31'b0, $signed(ra_q) < $signed(rb_q)};
          end
          FN_SLL:  begin x_wen = 1'b1; x_wd = rb_q << sh; end
          FN_SRL:  begin x_wen = 1'b1; x_wd = rb_q >> sh; end
          FN_SRA:  begin x_wen = 1'b1; x_wd = 32'($signed(rb_q) >>> sh); end
          FN_MFHI: begin x_wen = 1'b1; x_wd = hi; end
          FN_MFLO: begin x_wen = 1'b1; x_wd = lo; end
          FN_MULT: x_mult = 1'b1;
          FN_DIV:  x_div = 1'b1;
          FN_JR:   x_npc = ra_q;
          FN_SYSCALL: begin
            x_stop  = (ra_q == SYS_EXIT);
            x_print = (ra_q == SYS_PRINT_INT);
          end
          default: ;
        endcase
      end
      OP_LW, OP_LB, OP_LBU, OP_LH, OP_LHU: x_load = 1'b1;
      OP_SW, OP_SB, OP_SH:                 x_store = 1'b1;
      OP_LUI:  begin x_wen = 1'b1; x_wa = rt; x_wd = {imm, 16'b0}; end
      OP_ADDI: begin x_wen = 1'b1; x_wa = rt; x_wd = ra_q + simm; end
      OP_SLTI: begin
        x_wen = 1'b1; x_wa = rt;
        x_wd  = {31'b0, $signed(ra_q) < $signed(simm)};
      end
      OP_SLTIU: begin x_wen = 1'b1; x_wa = rt; x_wd = {31'b0, ra_q < simm}; end
      OP_ANDI: begin x_wen = 1'b1; x_wa = rt; x_wd = ra_q & uimm; end
      OP_ORI:  begin x_wen = 1'b1; x_wa = rt; x_wd = ra_q | uimm; end
      OP_XORI: begin x_wen = 1'b1; x_wa = rt; x_wd = ra_q ^ uimm; end
      OP_BEQ:  if (ra_q == rb_q) x_npc = pc4 + {simm[29:0], 2'b00};
      OP_BNE:  if (ra_q != rb_q) x_npc = pc4 + {simm[29:0], 2'b00};
      OP_BLEZ: if (ra_q == 32'd0 || ra_q[31]) x_npc = pc4 + {simm[29:0], 2'b00};
      OP_BGTZ: if (ra_q != 32'd0 && !ra_q[31]) x_npc = pc4 + {simm[29:0], 2'b00};
      OP_J:    x_npc = {pc4[31:28], ir[25:0], 2'b00};
      OP_JAL: begin
        x_wen = 1'b1;
        x_wa  = REG_RA;
        x_wd  = pc4;
        x_npc = {pc4[31:28], ir[25:0], 2'b00};
      end
      default: ;
    endcase
  end

  // load extract and store merge on the word read back
  assign bit_ofs   = {addr_q[1:0], 3'b000};
  assign bsh       = mem_q >> bit_ofs;
  assign hsh       = addr_q[1] ? {16'b0, mem_q[31:16]} : {16'b0, mem_q[15:0]};

  always_comb begin
    case (op)
      OP_LB:   ld_val = {{24{bsh[7]}}, bsh[7:0]};
      OP_LBU:  ld_val = {24'b0, bsh[7:0]};
      OP_LH:   ld_val = {{16{hsh[15]}}, hsh[15:0]};
      OP_LHU:  ld_val = hsh;
      default: ld_val = mem_q;
    endcase
    case (op)
      OP_SB: begin
        lane_mask = 32'h0000_00ff << bit_ofs;
        st_word   = (mem_q & ~lane_mask) | ({24'b0, rb_q[7:0]} << bit_ofs);
      end
      OP_SH: begin
        lane_mask = addr_q[1] ? 32'hffff_0000 : 32'h0000_ffff;
        st_word   = addr_q[1] ? {rb_q[15:0], mem_q[15:0]} : {mem_q[31:16], rb_q[15:0]};
      end
      default: begin
        lane_mask = 32'hffff_ffff;
        st_word   = rb_q;
      end
    endcase
  end

  // word memory: one write port, one registered read port
  always_comb begin
    mem_we = cmd.mem_wr_in || (cmd.mem_fin && x_store);
    mem_wa = cmd.mem_wr_in ? in_idx : byte_idx(addr_q);
    mem_wd = cmd.mem_wr_in ? in_data : st_word;
    if (cmd.mem_rd_in)  mem_ra = in_idx;
    else if (cmd.fetch) mem_ra = byte_idx(pc);
    else                mem_ra = byte_idx(addr_q);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.mem_rd_in || cmd.fetch || cmd.mem_rd_addr) mem_q <= mem[mem_ra];
  end

  // register file: valid bits stand for the zero reset, R0 is never written
  assign rf_we = (cmd.exec && x_wen) || (cmd.mem_fin && x_load);
  assign rf_wa = cmd.exec ? x_wa : rt;
  assign rf_wd = cmd.exec ? x_wd : ld_val;

  always_ff @(posedge clk) begin
    if (rst) rf_v <= '0;
    else if (rf_we && rf_wa != 5'd0) rf_v[rf_wa] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rf_we && rf_wa != 5'd0) rf[rf_wa] <= rf_wd;
    if (cmd.decode) begin
      ir   <= mem_q;
      ra_q <= rf_v[rd_a] ? rf[rd_a] : 32'd0;
      rb_q <= rf_v[rd_b] ? rf[rd_b] : 32'd0;
    end
    if (cmd.exec) addr_q <= addr;
  end

  // multiply and divide
  assign prod = 64'($signed(ra_q) * $signed(rb_q));

  mcore_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.exec && x_div),
    .dividend (ra_q),
    .divisor  (rb_q),
    .done     (div_done),
    .quo      (div_q),
    .rem      (div_r)
  );

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= 32'd0;
      hi      <= 32'd0;
      lo      <= 32'd0;
      stopped <= 1'b0;
      pr_v    <= 1'b0;
    end else begin
      if (cmd.load_in) pr_v <= 1'b0;
      if (cmd.exec) begin
        pc <= x_npc;
        if (x_stop)  stopped <= 1'b1;
        if (x_print) pr_v <= 1'b1;
        if (x_mult) begin
          hi <= prod[63:32];
          lo <= prod[31:0];
        end
      end
      if (div_done) begin
        hi <= div_r;
        lo <= div_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && x_print) pr_val <= rb_q;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_word       <= (mode_q == MODE_READ) ? mem_q : 32'd0;
      program_counter <= pc;
      halted          <= stopped;
      print_valid     <= pr_v;
      print_value     <= pr_v ? pr_val : 32'sd0;
    end
  end

  always_comb begin
    st          = '0;
    st.mode     = mode_q;
    st.stopped  = stopped;
    st.is_load  = x_load;
    st.is_store = x_store;
    st.is_div   = x_div;
    st.div_done = div_done;
    st.out_busy = out_valid && out_stall;
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    stopped |=> stopped) else $error("halt flag cleared");
  a_pc_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(pc)) else $error("pc moved outside execute");
  a_print_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(pr_v) |-> $past(cmd.exec)) else $error("print flag outside execute");

endmodule

### src/mips32_subset_core_top.sv
// mips32_subset_core_top: MIPS32 integer-subset core with a word memory.
// A write/read item passes dispatch, memory access and result; an instruction passes
// dispatch, fetch, decode, execute and result, loads and stores also a memory read and a
// write-back, DIV also a divider wait (one quotient bit per cycle). One item at a time; the
// next is taken the cycle after the result is registered, while it waits on out_stall.
// Reset clears PC, HI, LO, halt flag and register file; memory is undefined until written.
module mips32_subset_core_top
  import mcore_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [11:0] word_index,
  input  logic [31:0] write_word,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_word,
  output logic [31:0] program_counter,
  output logic        halted,
  output logic        print_valid,
  output logic signed [31:0] print_value
);

  cmd_t    cmd;
  status_t st;

  // sequencer: one state per step of the item
  mcore_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // memory, register file, ALU, multiply/divide and result register
  mcore_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .mode            (mode),
    .word_index      (word_index),
    .write_word      (write_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_word       (read_word),
    .program_counter (program_counter),
    .halted          (halted),
    .print_valid     (print_valid),
    .print_value     (print_value)
  );

endmodule

### bench/mips32_subset_core_top_test.sv
// Self-checking bench for mips32_subset_core_top: drives memory, read and execute items.
// A scoreboard class predicts each result from its own core model; needs mcore_pkg.
`timescale 1ns / 1ps

typedef struct {
  logic [31:0] read_word;
  logic [31:0] pc;
  logic        halted;
  logic        print_valid;
  logic [31:0] print_value;
} core_result_t;

class core_scoreboard;
  logic [31:0] mem [4096];
  bit          written [4096];
  int          written_list [$];
  logic [31:0] regs [32];
  logic [31:0] pc, hi, lo;
  bit          stop;
  core_result_t pending_q [$];
  int          errors, execs, prints, reads;

  function new();
    foreach (regs[i]) regs[i] = '0;
    pc = '0; hi = '0; lo = '0; stop = 0;
    errors = 0; execs = 0; prints = 0; reads = 0;
  endfunction

  function int pc_word();
    return int'(pc[13:2]);
  endfunction

  function void put_mem(int idx, logic [31:0] v);
    mem[idx] = v;
    if (!written[idx]) begin
      written[idx] = 1;
      written_list.push_back(idx);
    end
  endfunction

  function void set_reg(logic [4:0] r, logic [31:0] v);
    if (r != 0) regs[r] = v;
  endfunction

  function void divide(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q, r;
    if (b == 0) begin
      lo = 32'hffffffff;
      hi = a;
      return;
    end
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    lo = (a[31] != b[31]) ? -q : q;
    hi = a[31] ? -r : r;
  endfunction

  // run one instruction; returns 1 if it printed
  function bit run_one();
    logic [31:0] ins, a, b, simm, addr, npc, w, m;
    logic signed [63:0] prod;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    int          idx, lane;
    bit          printed;
    ins = mem[pc_word()];
    op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
    sh = ins[10:6]; fn = ins[5:0];
    simm = {{16{ins[15]}}, ins[15:0]};
    a = regs[rs]; b = regs[rt];
    addr = a + simm;
    idx = int'(addr[13:2]);
    npc = pc + 4;
    printed = 0;
    if (op == mcore_pkg::OP_SPECIAL) begin
      case (fn)
        mcore_pkg::FN_ADD: set_reg(rd, a + b);
        mcore_pkg::FN_SUB: set_reg(rd, a - b);
        mcore_pkg::FN_MULT: begin
          prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          hi = prod[63:32];
          lo = prod[31:0];
        end
        mcore_pkg::FN_DIV: divide(a, b);
        mcore_pkg::FN_AND: set_reg(rd, a & b);
        mcore_pkg::FN_OR:  set_reg(rd, a | b);
        mcore_pkg::FN_XOR: set_reg(rd, a ^ b);
        mcore_pkg::FN_NOR: set_reg(rd, ~(a | b));
        mcore_pkg::FN_SLT: set_reg(rd, {31'b0, $signed(a) < $signed(b)});
        mcore_pkg::FN_JR:  npc = a;
        mcore_pkg::FN_SLL: set_reg(rd, b << sh);
        mcore_pkg::FN_SRL: set_reg(rd, b >> sh);
        mcore_pkg::FN_SRA: set_reg(rd, $signed(b) >>> sh);
        mcore_pkg::FN_SYSCALL: begin
          if (regs[mcore_pkg::REG_V0] == mcore_pkg::SYS_EXIT) stop = 1;
          else if (regs[mcore_pkg::REG_V0] == mcore_pkg::SYS_PRINT_INT) printed = 1;
        end
        mcore_pkg::FN_MFHI: set_reg(rd, hi);
        mcore_pkg::FN_MFLO: set_reg(rd, lo);
        default: ;
      endcase
    end else begin
      case (op)
        mcore_pkg::OP_LW: set_reg(rt, mem[idx]);
        mcore_pkg::OP_LB, mcore_pkg::OP_LBU: begin
          lane = addr[1:0] * 8;
          w = (mem[idx] >> lane) & 32'hff;
          set_reg(rt, (op == mcore_pkg::OP_LB) ? {{24{w[7]}}, w[7:0]} : w);
        end
        mcore_pkg::OP_LH, mcore_pkg::OP_LHU: begin
          lane = addr[1] * 16;
          w = (mem[idx] >> lane) & 32'hffff;
          set_reg(rt, (op == mcore_pkg::OP_LH) ? {{16{w[15]}}, w[15:0]} : w);
        end
        mcore_pkg::OP_LUI: set_reg(rt, {ins[15:0], 16'h0});
        mcore_pkg::OP_SW:  put_mem(idx, b);
        mcore_pkg::OP_SB: begin
          lane = addr[1:0] * 8;
          m = 32'hff << lane;
          put_mem(idx, (mem[idx] & ~m) | ((b & 32'hff) << lane));
        end
        mcore_pkg::OP_SH: begin
          lane = addr[1] * 16;
          m = 32'hffff << lane;
          put_mem(idx, (mem[idx] & ~m) | ((b & 32'hffff) << lane));
        end
        mcore_pkg::OP_BEQ:  if (a == b) npc += simm << 2;
        mcore_pkg::OP_BNE:  if (a != b) npc += simm << 2;
        mcore_pkg::OP_BLEZ: if (a == 0 || a[31]) npc += simm << 2;
        mcore_pkg::OP_BGTZ: if (a != 0 && !a[31]) npc += simm << 2;
        mcore_pkg::OP_ADDI:  set_reg(rt, addr);
        mcore_pkg::OP_SLTI:  set_reg(rt, {31'b0, $signed(a) < $signed(simm)});
        mcore_pkg::OP_SLTIU: set_reg(rt, {31'b0, a < simm});
        mcore_pkg::OP_ANDI:  set_reg(rt, a & {16'h0, ins[15:0]});
        mcore_pkg::OP_ORI:   set_reg(rt, a | {16'h0, ins[15:0]});
        mcore_pkg::OP_XORI:  set_reg(rt, a ^ {16'h0, ins[15:0]});
        mcore_pkg::OP_J:   npc = {npc[31:28], ins[25:0], 2'b00};
        mcore_pkg::OP_JAL: begin
          set_reg(mcore_pkg::REG_RA, pc + 4);
          npc = {npc[31:28], ins[25:0], 2'b00};
        end
        default: ;
      endcase
    end
    pc = npc;
    return printed;
  endfunction

  // note an accepted input item and queue its expected result
  function void note(logic [1:0] m, logic [11:0] idx, logic [31:0] d);
    core_result_t r;
    r.read_word = '0;
    r.print_valid = 0;
    r.print_value = '0;
    if (m == mcore_pkg::MODE_WRITE) put_mem(int'(idx), d);
    else if (m == mcore_pkg::MODE_READ) begin
      r.read_word = mem[idx];
      reads++;
    end else if (m == mcore_pkg::MODE_EXEC && !stop) begin
      execs++;
      if (run_one()) begin
        r.print_valid = 1;
        r.print_value = regs[mcore_pkg::REG_A0];
        prints++;
      end
    end
    r.pc = pc;
    r.halted = stop;
    pending_q.push_back(r);
  endfunction

  function void check(core_result_t got);
    core_result_t want;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result pc=%h", $time, got.pc);
      errors++;
      return;
    end
    want = pending_q.pop_front();
    if (got.read_word !== want.read_word) begin
      $display("%0t: read_word exp %h got %h", $time, want.read_word, got.read_word);
      errors++;
    end
    if (got.pc !== want.pc) begin
      $display("%0t: program_counter exp %h got %h", $time, want.pc, got.pc);
      errors++;
    end
    if (got.halted !== want.halted) begin
      $display("%0t: halted exp %b got %b", $time, want.halted, got.halted);
      errors++;
    end
    if (got.print_valid !== want.print_valid) begin
      $display("%0t: print_valid exp %b got %b", $time, want.print_valid, got.print_valid);
      errors++;
    end
    if (got.print_value !== want.print_value) begin
      $display("%0t: print_value exp %h got %h", $time, want.print_value, got.print_value);
      errors++;
    end
  endfunction
endclass

module mips32_subset_core_top_test;
  import mcore_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;  // outside the defined modes

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  mode = '0;
  logic [11:0] word_index = '0;
  logic [31:0] write_word = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] read_word;
  logic [31:0] program_counter;
  logic        halted;
  logic        print_valid;
  logic signed [31:0] print_value;

  core_scoreboard sb = new();
  int idle_pct  = 0;   // chance per cycle that the sender holds back
  int stall_pct = 0;   // chance per cycle that the receiver stalls
  int hold_req  = 0;   // bump to ask the receiver for a long hold-off
  int hold_seen = 0;
  int hold_left = 0;

  mips32_subset_core_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .word_index(word_index), .write_word(write_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_word(read_word), .program_counter(program_counter), .halted(halted),
    .print_valid(print_valid), .print_value(print_value)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver: random stalls, plus a long hold-off on request so the core
  // backs up and stalls its item input while the sender keeps offering.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Check every result the moment it is taken.
  always @(posedge clk) begin
    core_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.read_word = read_word;
      got.pc = program_counter;
      got.halted = halted;
      got.print_valid = print_valid;
      got.print_value = print_value;
      sb.check(got);
    end
  end

  // Offer one item, hold it until taken, then log it with the scoreboard.
  // Predictor state is current on return, so callers may build on it.
  task automatic send(logic [1:0] m, logic [11:0] idx, logic [31:0] d);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    mode <= m;
    word_index <= idx;
    write_word <= d;
    do @(posedge clk); while (in_stall);
    sb.note(m, idx, d);
  endtask

  // Place an instruction at the current PC, then execute it.
  task automatic run_instr(logic [31:0] ins);
    send(MODE_WRITE, 12'(sb.pc_word()), ins);
    send(MODE_EXEC, 12'($urandom), $urandom);
  endtask

  function automatic logic [31:0] r_type(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sh, logic [5:0] fn);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Build a random instruction that only touches memory already written.
  function automatic logic [31:0] pick_instr();
    logic [5:0]  alu_fn [12] = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT,
                                 FN_SLL, FN_SRL, FN_SRA, FN_MFHI, FN_MFLO};
    logic [5:0]  imm_op [7] = '{OP_ADDI, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI};
    logic [5:0]  mem_op [8] = '{OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW};
    logic [5:0]  br_op [4] = '{OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ};
    logic [5:0]  bad_op [4] = '{6'h01, 6'h09, 6'h10, 6'h3f};
    logic [4:0]  rs, rt, rd, sh;
    logic [15:0] imm;
    logic [13:0] target, low;
    int          k;
    k = $urandom_range(0, 99);
    rs = 5'($urandom); rt = 5'($urandom); rd = 5'($urandom); sh = 5'($urandom);
    imm = 16'($urandom);
    if (k < 28) return r_type(rs, rt, rd, sh, alu_fn[$urandom_range(0, 11)]);
    if (k < 36) begin
      if ($urandom_range(0, 3) == 0) rt = 5'd0;  // divide by zero now and then
      return r_type(rs, rt, 5'd0, 5'd0, $urandom_range(0, 1) ? FN_MULT : FN_DIV);
    end
    if (k < 52) return i_type(imm_op[$urandom_range(0, 6)], rs, rt, imm);
    if (k < 68) begin
      // aim the effective address at a written word, any byte lane
      target = 14'(sb.written_list[$urandom_range(0, sb.written_list.size() - 1)] * 4
                   + $urandom_range(0, 3));
      low = target - sb.regs[rs][13:0];
      return i_type(mem_op[$urandom_range(0, 7)], rs, rt, {2'($urandom), low});
    end
    if (k < 78) return i_type(br_op[$urandom_range(0, 3)], rs, rt, imm);
    if (k < 84) begin
      case ($urandom_range(0, 2))
        0: return {OP_J, 26'($urandom)};
        1: return {OP_JAL, 26'($urandom)};
        default: return r_type(rs, 5'd0, 5'd0, 5'd0, FN_JR);
      endcase
    end
    if (k < 89) begin
      // load a syscall service number, never the exit one
      case ($urandom_range(0, 2))
        0: imm = 16'(SYS_PRINT_INT);
        1: imm = 16'd4;
        default: imm = 16'($urandom_range(11, 200));
      endcase
      return i_type(OP_ADDI, 5'd0, REG_V0, imm);
    end
    if (k < 95) begin
      if (sb.regs[REG_V0] == SYS_EXIT) return r_type(rs, rt, rd, 5'd0, FN_ADD);
      return r_type(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL);
    end
    if ($urandom_range(0, 1)) return r_type(rs, rt, rd, sh, 6'h01);
    return i_type(bad_op[$urandom_range(0, 3)], rs, rt, imm);
  endfunction

  // Limit: well past the slowest correct run.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int n, wait_cycles, k;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, unknown mode, and the arithmetic corner cases.
    send(MODE_WRITE, 12'd0, 32'h0);
    send(MODE_WRITE, 12'd4095, 32'hffffffff);
    send(MODE_READ, 12'd4095, 32'h0);
    send(MODE_READ, 12'd0, 32'hffffffff);
    send(MODE_NONE, 12'hfff, 32'hffffffff);
    run_instr(i_type(OP_LUI, 5'd0, 5'd8, 16'h8000));
    run_instr(i_type(OP_ADDI, 5'd0, 5'd9, 16'hffff));
    run_instr(r_type(5'd8, 5'd9, 5'd0, 5'd0, FN_DIV));       // signed overflow divide
    run_instr(r_type(5'd0, 5'd0, 5'd10, 5'd0, FN_MFLO));
    run_instr(r_type(5'd9, 5'd0, 5'd0, 5'd0, FN_DIV));       // divide by zero
    run_instr(r_type(5'd0, 5'd0, 5'd11, 5'd0, FN_MFHI));
    run_instr(r_type(5'd8, 5'd8, 5'd12, 5'd0, FN_ADD));      // wraps, no trap
    run_instr(i_type(OP_SLTIU, 5'd8, 5'd4, 16'hffff));       // sign-extended, unsigned compare
    run_instr(i_type(OP_ADDI, 5'd0, REG_V0, 16'(SYS_PRINT_INT)));
    run_instr(r_type(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));

    // Seed a data region so loads and partial stores always hit written words.
    for (int i = 0; i < 32; i++) send(MODE_WRITE, 12'(1024 + i), $urandom);

    // Random: mostly instruction sequences, with reads, writes and stray modes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      if (phase == 0) hold_req++;
      n = 0;
      while (n < 260) begin
        k = $urandom_range(0, 99);
        if (k < 75) begin
          run_instr(pick_instr());
          n += 2;
        end else if (k < 87) begin
          send(MODE_READ, 12'(sb.written_list[$urandom_range(0, sb.written_list.size() - 1)]),
               $urandom);
          n++;
        end else if (k < 97) begin
          send(MODE_WRITE, 12'($urandom), $urandom);
          n++;
        end else begin
          send(MODE_NONE, 12'($urandom), $urandom);
          n++;
        end
      end
    end

    // Halt the core, then show that execute does nothing while memory still works.
    idle_pct = 0;
    stall_pct = 24;
    run_instr(i_type(OP_ADDI, 5'd0, REG_V0, 16'(SYS_EXIT)));
    run_instr(r_type(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
    send(MODE_EXEC, 12'($urandom), $urandom);
    send(MODE_WRITE, 12'd7, 32'h5a5a_a5a5);
    send(MODE_READ, 12'd7, 32'h0);
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending_q.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);

    $display("Covered %0d executed instructions, %0d prints, %0d memory reads",
             sb.execs, sb.prints, sb.reads);
    $display("across four idle/stall phases with a long output hold-off and a final halt.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
src/mcore_pkg.sv
src/mcore_div.sv
src/mcore_ctrl.sv
src/mcore_dp.sv
src/mips32_subset_core_top.sv
bench/mips32_subset_core_top_test.sv
